FILE: rtl/tcr_pkg.sv
// tcr_pkg: shared types, constants and codes of the type-code registry
// no dependencies; imported by the interfaces and every module of the block

package tcr_pkg;

  localparam int unsigned CODE_BITS        = 64;
  localparam int unsigned HIGH_SHIFT       = 32;
  localparam int unsigned WAY_DEPTH_DEF    = 256;
  localparam int unsigned CORE_CODES_DEF   = 128;
  localparam int unsigned MAX_KICKS_DEF    = 64;
  localparam int unsigned HANDLE_BITS_DEF  = 16;
  localparam int unsigned STATUS_BITS      = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_ZERO = 2'd2,
    STAT_FAIL = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_CORE_RD,
    S_IDX1_GO,
    S_IDX1_WAIT,
    S_IDX2_GO,
    S_IDX2_WAIT,
    S_LK_RD,
    S_LK_CMP,
    S_W1_RD,
    S_W1_SWAP,
    S_W2_RD,
    S_W2_SWAP,
    S_RESP
  } fsm_e;

  // request to the shared index (modulo) unit
  typedef struct packed {
    logic                 start;
    logic [CODE_BITS-1:0] operand;
  } mod_req_t;

endpackage

FILE: rtl/tcr_req_if.sv
// tcr_req_if: valid/ready request channel carrying opcode, type code and handle
// depends on tcr_pkg

interface tcr_req_if import tcr_pkg::*; #(
  parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   opcode;
  logic [CODE_BITS-1:0]   code;
  logic [HANDLE_BITS-1:0] entry_handle;

  modport source (output valid, output opcode, output code, output entry_handle,
                  input ready);
  modport sink   (input valid, input opcode, input code, input entry_handle,
                  output ready);
endinterface

FILE: rtl/tcr_rsp_if.sv
// tcr_rsp_if: valid/ready response channel carrying status and found handle
// depends on tcr_pkg

interface tcr_rsp_if import tcr_pkg::*; #(
  parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic [HANDLE_BITS-1:0] found_handle;

  modport source (output valid, output status, output found_handle, input ready);
  modport sink   (input valid, input status, input found_handle, output ready);
endinterface

FILE: rtl/tcr_mod_unit.sv
// tcr_mod_unit: shared index unit, remainder of a 64-bit code by the way depth
// depends on tcr_pkg; a part-select for power-of-two depths, else reciprocal
// multiplication over 16-bit chunks

module tcr_mod_unit import tcr_pkg::*; #(
  parameter  int unsigned WAY_DEPTH = WAY_DEPTH_DEF,
  localparam int unsigned IB        = $clog2(WAY_DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mod_req_t      req_i,
  output logic          done_o,
  output logic [IB-1:0] rem_o
);

  localparam bit IS_POW2 = (WAY_DEPTH & (WAY_DEPTH - 1)) == 0;

  logic          done_q;
  logic [IB-1:0] rem_q;

  assign done_o = done_q;
  assign rem_o  = rem_q;

  if (IS_POW2) begin : g_pow2
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= req_i.start;
      end
    end

    always_ff @(posedge clk_i) begin
      if (req_i.start) begin
        rem_q <= req_i.operand[IB-1:0];
      end
    end
  end else begin : g_recip
    localparam int unsigned CHUNK  = 16;
    localparam int unsigned TW     = 2 * CHUNK;
    localparam int unsigned NCHUNK = CODE_BITS / CHUNK;
    localparam int unsigned CNTB   = $clog2(NCHUNK);
    localparam int unsigned SHR    = TW + IB;
    localparam logic [63:0] PW      = 64'd1 << SHR;
    localparam logic [63:0] RECIP_W = PW / 64'(WAY_DEPTH) + 64'd1;
    localparam logic [TW:0] RECIP   = RECIP_W[TW:0];

    logic                 busy_q;
    logic                 phase_q;
    logic [CNTB-1:0]      cnt_q;
    logic [CODE_BITS-1:0] opnd_q;
    logic [CHUNK-1:0]     quo_q;
    logic [TW-1:0]        t;
    logic [2*TW:0]        prod;
    logic [TW-1:0]        rem_w;
    logic                 last;

    // rem = (rem * 2^16 + chunk) mod depth, top chunk first
    // quotient by reciprocal in one phase, multiply-subtract in the next
    assign t     = {CHUNK'(rem_q), opnd_q[CODE_BITS-1 -: CHUNK]};
    assign prod  = {{(TW+1){1'b0}}, t} * {{TW{1'b0}}, RECIP};
    assign rem_w = t - TW'(quo_q) * TW'(WAY_DEPTH);
    assign last  = phase_q && (cnt_q == CNTB'(NCHUNK - 1));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q  <= 1'b0;
        done_q  <= 1'b0;
        phase_q <= 1'b0;
        cnt_q   <= '0;
      end else begin
        done_q <= busy_q && last;
        if (req_i.start) begin
          busy_q  <= 1'b1;
          phase_q <= 1'b0;
          cnt_q   <= '0;
        end else if (busy_q) begin
          phase_q <= !phase_q;
          if (phase_q) begin
            cnt_q <= cnt_q + 1'b1;
            if (last) begin
              busy_q <= 1'b0;
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (req_i.start) begin
        opnd_q <= req_i.operand;
        rem_q  <= '0;
      end else if (busy_q) begin
        if (!phase_q) begin
          quo_q <= prod[SHR +: CHUNK];
        end else begin
          rem_q  <= rem_w[IB-1:0];
          opnd_q <= {opnd_q[CODE_BITS-CHUNK-1:0], {CHUNK{1'b0}}};
        end
      end
    end
  end

endmodule

FILE: rtl/type_code_registry_cuckoo.sv
// type_code_registry_cuckoo: core table plus two-way cuckoo hash for type codes
// flow: core codes use the core table directly; other codes get two indices from the
//   shared index unit, lookups then read both ways and inserts displace entries for up
//   to MAX_KICKS rounds; each response may wait for the response channel
// throughput: one item at a time, not ready until its result is registered
// reset: clearing pass over max(WAY_DEPTH, CORE_CODES) entries, no transfer taken

module type_code_registry_cuckoo import tcr_pkg::*; #(
  parameter int unsigned WAY_DEPTH   = WAY_DEPTH_DEF,
  parameter int unsigned CORE_CODES  = CORE_CODES_DEF,
  parameter int unsigned MAX_KICKS   = MAX_KICKS_DEF,
  parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  tcr_req_if.sink   req_i,
  tcr_rsp_if.source rsp_o
);

  localparam int unsigned IB        = $clog2(WAY_DEPTH);
  localparam int unsigned CB        = (CORE_CODES > 1) ? $clog2(CORE_CODES) : 1;
  localparam int unsigned KB        = (MAX_KICKS > 1) ? $clog2(MAX_KICKS) : 1;
  localparam int unsigned CLR_DEPTH = (WAY_DEPTH > CORE_CODES) ? WAY_DEPTH : CORE_CODES;
  localparam int unsigned CLRB      = $clog2(CLR_DEPTH);

  typedef struct packed {
    logic                   valid;
    logic [CODE_BITS-1:0]   key;
    logic [HANDLE_BITS-1:0] handle;
  } way_ent_t;

  typedef struct packed {
    logic                   valid;
    logic [HANDLE_BITS-1:0] handle;
  } core_ent_t;

  // storage
  core_ent_t core_mem [CORE_CODES];
  way_ent_t  w1_mem   [WAY_DEPTH];
  way_ent_t  w2_mem   [WAY_DEPTH];

  core_ent_t core_rd_q;
  way_ent_t  w1_rd_q, w2_rd_q;

  logic           core_we, w1_we, w2_we;
  logic [CB-1:0]  core_waddr;
  logic [IB-1:0]  w_clr_addr;
  logic [IB-1:0]  w1_waddr, w2_waddr;
  core_ent_t      core_wdata;
  way_ent_t       w1_wdata, w2_wdata;

  // control and item state
  fsm_e                   state_q, state_d;
  logic                   op_q;
  logic [CODE_BITS-1:0]   code_q, code_d;
  logic [HANDLE_BITS-1:0] hdl_q, hdl_d;
  logic [IB-1:0]          a_q, a_d, b_q, b_d;
  logic [KB-1:0]          kick_q, kick_d;
  logic [CLRB-1:0]        clr_q, clr_d;
  status_e                pend_stat_q, pend_stat_d;
  logic [HANDLE_BITS-1:0] pend_hdl_q, pend_hdl_d;
  logic                   out_valid_q, out_valid_d;
  logic [STATUS_BITS-1:0] out_stat_q, out_stat_d;
  logic [HANDLE_BITS-1:0] out_hdl_q, out_hdl_d;

  logic                   req_xfer, rsp_xfer;
  logic                   is_core, clr_last, clr_way, clr_core, kick_last;
  logic                   w1_hit, w2_hit, out_free;
  mod_req_t               mod_req;
  logic                   mod_done;
  logic [IB-1:0]          mod_rem;

  assign req_i.ready        = state_q == S_IDLE;
  assign req_xfer           = req_i.valid && req_i.ready;
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_stat_q;
  assign rsp_o.found_handle = out_hdl_q;
  assign rsp_xfer           = out_valid_q && rsp_o.ready;
  assign out_free           = !out_valid_q || rsp_o.ready;

  assign is_core   = code_q < CODE_BITS'(CORE_CODES);
  assign clr_last  = clr_q == CLRB'(CLR_DEPTH - 1);
  assign clr_way   = {1'b0, clr_q} < (CLRB+1)'(WAY_DEPTH);
  assign clr_core  = {1'b0, clr_q} < (CLRB+1)'(CORE_CODES);
  assign w_clr_addr = clr_q[IB-1:0];
  assign kick_last = kick_q == KB'(MAX_KICKS - 1);
  assign w1_hit    = w1_rd_q.valid && (w1_rd_q.key == code_q);
  assign w2_hit    = w2_rd_q.valid && (w2_rd_q.key == code_q);

  tcr_mod_unit #(
    .WAY_DEPTH (WAY_DEPTH)
  ) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:     if (clr_last) state_d = S_IDLE;
      S_IDLE:      if (req_xfer) state_d = S_DISPATCH;
      S_DISPATCH: begin
        if (op_q == OP_INSERT && code_q == '0) begin
          state_d = S_RESP;
        end else if (is_core) begin
          state_d = (op_q == OP_INSERT) ? S_RESP : S_CORE_RD;
        end else begin
          state_d = S_IDX1_GO;
        end
      end
      S_CORE_RD:   state_d = S_RESP;
      S_IDX1_GO:   state_d = S_IDX1_WAIT;
      S_IDX1_WAIT: if (mod_done) state_d = (op_q == OP_LOOKUP) ? S_IDX2_GO : S_W1_RD;
      S_IDX2_GO:   state_d = S_IDX2_WAIT;
      S_IDX2_WAIT: if (mod_done) state_d = (op_q == OP_LOOKUP) ? S_LK_RD : S_W2_RD;
      S_LK_RD:     state_d = S_LK_CMP;
      S_LK_CMP:    state_d = S_RESP;
      S_W1_RD:     state_d = S_W1_SWAP;
      S_W1_SWAP:   state_d = w1_rd_q.valid ? S_IDX2_GO : S_RESP;
      S_W2_RD:     state_d = S_W2_SWAP;
      S_W2_SWAP: begin
        if (!w2_rd_q.valid || kick_last) begin
          state_d = S_RESP;
        end else begin
          state_d = S_IDX1_GO;
        end
      end
      S_RESP:      if (out_free) state_d = S_IDLE;
      default:     state_d = S_CLEAR;
    endcase
  end

  // datapath and outputs
  always_comb begin
    code_d      = code_q;
    hdl_d       = hdl_q;
    a_d         = a_q;
    b_d         = b_q;
    kick_d      = kick_q;
    clr_d       = clr_q;
    pend_stat_d = pend_stat_q;
    pend_hdl_d  = pend_hdl_q;
    out_valid_d = out_valid_q && !rsp_xfer;
    out_stat_d  = out_stat_q;
    out_hdl_d   = out_hdl_q;
    mod_req     = '{start: 1'b0, operand: code_q};
    core_we     = 1'b0;
    core_waddr  = code_q[CB-1:0];
    core_wdata  = '{valid: 1'b1, handle: hdl_q};
    w1_we       = 1'b0;
    w1_waddr    = a_q;
    w1_wdata    = '{valid: 1'b1, key: code_q, handle: hdl_q};
    w2_we       = 1'b0;
    w2_waddr    = b_q;
    w2_wdata    = '{valid: 1'b1, key: code_q, handle: hdl_q};

    case (state_q)
      S_CLEAR: begin
        clr_d      = clr_q + 1'b1;
        core_we    = clr_core;
        core_waddr = clr_q[CB-1:0];
        core_wdata = '0;
        w1_we      = clr_way;
        w1_waddr   = w_clr_addr;
        w1_wdata   = '0;
        w2_we      = clr_way;
        w2_waddr   = w_clr_addr;
        w2_wdata   = '0;
      end
      S_IDLE: begin
        code_d = req_i.code;
        hdl_d  = req_i.entry_handle;
        kick_d = '0;
      end
      S_DISPATCH: begin
        pend_stat_d = STAT_OK;
        pend_hdl_d  = '0;
        if (op_q == OP_INSERT && code_q == '0) begin
          pend_stat_d = STAT_ZERO;
        end else if (is_core && op_q == OP_INSERT) begin
          core_we = 1'b1;
        end
      end
      S_CORE_RD: begin
        if (core_rd_q.valid) begin
          pend_hdl_d = core_rd_q.handle;
        end else begin
          pend_stat_d = STAT_MISS;
        end
      end
      S_IDX1_GO:   mod_req.start = 1'b1;
      S_IDX1_WAIT: if (mod_done) a_d = mod_rem;
      S_IDX2_GO: begin
        mod_req.start   = 1'b1;
        mod_req.operand = {{HIGH_SHIFT{1'b0}}, code_q[CODE_BITS-1:HIGH_SHIFT]};
      end
      S_IDX2_WAIT: if (mod_done) b_d = mod_rem;
      S_LK_CMP: begin
        if (w1_hit) begin
          pend_hdl_d = w1_rd_q.handle;
        end else if (w2_hit) begin
          pend_hdl_d = w2_rd_q.handle;
        end else begin
          pend_stat_d = STAT_MISS;
        end
      end
      S_W1_SWAP: begin
        w1_we  = 1'b1;
        code_d = w1_rd_q.key;
        hdl_d  = w1_rd_q.handle;
      end
      S_W2_SWAP: begin
        w2_we  = 1'b1;
        code_d = w2_rd_q.key;
        hdl_d  = w2_rd_q.handle;
        kick_d = kick_q + 1'b1;
        if (w2_rd_q.valid && kick_last) begin
          pend_stat_d = STAT_FAIL;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_stat_d  = pend_stat_q;
          out_hdl_d   = pend_hdl_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      kick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      kick_q      <= kick_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      op_q <= req_i.opcode;
    end
    code_q      <= code_d;
    hdl_q       <= hdl_d;
    a_q         <= a_d;
    b_q         <= b_d;
    pend_stat_q <= pend_stat_d;
    pend_hdl_q  <= pend_hdl_d;
    out_stat_q  <= out_stat_d;
    out_hdl_q   <= out_hdl_d;
  end

  // memories: one write and one registered read port each
  always_ff @(posedge clk_i) begin
    if (core_we) begin
      core_mem[core_waddr] <= core_wdata;
    end
    core_rd_q <= core_mem[code_q[CB-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (w1_we) begin
      w1_mem[w1_waddr] <= w1_wdata;
    end
    w1_rd_q <= w1_mem[a_q];
  end

  always_ff @(posedge clk_i) begin
    if (w2_we) begin
      w2_mem[w2_waddr] <= w2_wdata;
    end
    w2_rd_q <= w2_mem[b_q];
  end

endmodule
